>>> rtl/core/pmq_pkg.sv
// Shared constants and helpers for the pose matrix to quaternion pipeline.
// Used by pmq_col_norm and pose_matrix_to_quaternion; depends on nothing.
`default_nettype none

package pmq_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QUAT_BITS     = 18;
    localparam int POS_BITS      = 32;

    localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
    localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};

    // Register stages through one column normalizer.
    function automatic int cn_latency(input int frac_bits);
        return frac_bits + 41;
    endfunction

    function automatic logic signed [QUAT_BITS-1:0] sat_quat(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (QUAT_BITS - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi)
        begin
            return QUAT_BITS'(hi);
        end
        else if (v < lo)
        begin
            return QUAT_BITS'(lo);
        end
        return QUAT_BITS'(v);
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/pmq_col_norm.sv
// Pipelined unit-length scaling of one rotation column.
// Depends on pmq_pkg for the default fraction width.
`default_nettype none

module pmq_col_norm #(
    parameter int FRAC_BITS = pmq_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        adv,
    input  logic signed [31:0]          ent [3],
    output logic signed [FRAC_BITS+1:0] nrm [3]
);

    localparam int QB  = FRAC_BITS + 2;
    localparam int NW  = 32 + QB;
    localparam int SHW = 63 + FRAC_BITS;
    localparam logic [63:0]   UNIT  = 64'd1 << (2 * FRAC_BITS);
    localparam logic [QB-1:0] ONE_Q = QB'(1) << FRAC_BITS;

    typedef struct packed {
        logic             byp;
        logic [4:0]       e;
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
    } side_t;

    logic [2:0]       neg1_reg, neg2_reg, neg3_reg;
    logic [2:0][31:0] mag1_reg, mag2_reg, mag3_reg;
    logic [2:0][31:0] mag1_next;
    logic [2:0][63:0] sq2_reg;
    logic [63:0]      len3_reg, len4_reg, x5_reg;
    side_t            side4_reg, side5_reg, side4_next;

    logic [63:0] srem_reg [32];
    logic [63:0] srem_next [32];
    logic [31:0] sroot_reg [32];
    logic [31:0] sroot_next [32];
    side_t       sside_reg [32];
    side_t       sside_next [32];

    logic [2:0][NW-1:0] num_reg, num_next;
    logic [31:0]        nden_reg;
    side_t              nside_reg;

    logic [2:0][NW-1:0] drem_reg [QB];
    logic [2:0][NW-1:0] drem_next [QB];
    logic [2:0][QB-1:0] dq_reg [QB];
    logic [2:0][QB-1:0] dq_next [QB];
    logic [31:0]        dden_reg [QB];
    logic [31:0]        dden_next [QB];
    side_t              dside_reg [QB];
    side_t              dside_next [QB];

    always_comb
    begin
        logic [31:0] eu;
        for (int k = 0; k < 3; k++)
        begin
            eu = ent[k];
            mag1_next[k] = eu[31] ? (~eu + 32'd1) : eu;
        end
    end

    // Shift count: pairs of leading zeros, so the root keeps 32 significant bits.
    always_comb
    begin
        side4_next     = '0;
        side4_next.neg = neg3_reg;
        side4_next.mag = mag3_reg;
        for (int i = 0; i < 32; i++)
        begin
            if (len3_reg[2*i +: 2] != 2'b00)
            begin
                side4_next.e = 5'(31 - i);
            end
        end
        side4_next.byp = (len3_reg == 64'd0) || (len3_reg == UNIT);
    end

    always_comb
    begin
        logic [63:0] rin;
        logic [31:0] qin;
        logic [64:0] trial;
        for (int j = 0; j < 32; j++)
        begin
            if (j == 0)
            begin
                rin           = x5_reg;
                qin           = '0;
                sside_next[j] = side5_reg;
            end
            else
            begin
                rin           = srem_reg[j-1];
                qin           = sroot_reg[j-1];
                sside_next[j] = sside_reg[j-1];
            end
            trial = ({33'd0, qin} << (32 - j)) + (65'd1 << (2 * (31 - j)));
            if ({1'b0, rin} >= trial)
            begin
                srem_next[j]  = rin - trial[63:0];
                sroot_next[j] = qin | (32'd1 << (31 - j));
            end
            else
            begin
                srem_next[j]  = rin;
                sroot_next[j] = qin;
            end
        end
    end

    always_comb
    begin
        logic [SHW-1:0] wide;
        for (int k = 0; k < 3; k++)
        begin
            wide = {{(SHW-32){1'b0}}, sside_reg[31].mag[k]} << (FRAC_BITS + sside_reg[31].e);
            num_next[k] = NW'(wide) + NW'(sroot_reg[31] >> 1);
        end
    end

    always_comb
    begin
        logic [2:0][NW-1:0] rin;
        logic [2:0][QB-1:0] qin;
        logic [31:0]        din;
        logic [NW-1:0]      dd;
        for (int j = 0; j < QB; j++)
        begin
            if (j == 0)
            begin
                rin           = num_reg;
                qin           = '0;
                din           = nden_reg;
                dside_next[j] = nside_reg;
            end
            else
            begin
                rin           = drem_reg[j-1];
                qin           = dq_reg[j-1];
                din           = dden_reg[j-1];
                dside_next[j] = dside_reg[j-1];
            end
            dd           = {{(NW-32){1'b0}}, din} << (QB - 1 - j);
            dden_next[j] = din;
            for (int k = 0; k < 3; k++)
            begin
                if (rin[k] >= dd)
                begin
                    drem_next[j][k] = rin[k] - dd;
                    dq_next[j][k]   = qin[k] | (QB'(1) << (QB - 1 - j));
                end
                else
                begin
                    drem_next[j][k] = rin[k];
                    dq_next[j][k]   = qin[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag1_reg <= mag1_next;
            for (int k = 0; k < 3; k++)
            begin
                neg1_reg[k] <= ent[k][31];
                sq2_reg[k]  <= mag1_reg[k] * mag1_reg[k];
            end
            neg2_reg  <= neg1_reg;
            mag2_reg  <= mag1_reg;
            len3_reg  <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
            neg3_reg  <= neg2_reg;
            mag3_reg  <= mag2_reg;
            len4_reg  <= len3_reg;
            side4_reg <= side4_next;
            x5_reg    <= len4_reg << {side4_reg.e, 1'b0};
            side5_reg <= side4_reg;
            srem_reg  <= srem_next;
            sroot_reg <= sroot_next;
            sside_reg <= sside_next;
            num_reg   <= num_next;
            nden_reg  <= sroot_reg[31];
            nside_reg <= sside_reg[31];
            drem_reg  <= drem_next;
            dq_reg    <= dq_next;
            dden_reg  <= dden_next;
            dside_reg <= dside_next;
        end
    end

    // Rounding can step just past 1.0; a zero or unit column passes unscaled.
    always_ff @(posedge clk)
    begin
        logic [QB-1:0] q;
        logic [QB-1:0] val;
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                q   = dq_reg[QB-1][k];
                val = dside_reg[QB-1].byp ? dside_reg[QB-1].mag[k][QB-1:0]
                                          : ((q > ONE_Q) ? ONE_Q : q);
                nrm[k] <= dside_reg[QB-1].neg[k] ? signed'(~val + QB'(1)) : signed'(val);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/pose_matrix_to_quaternion.sv
// Top level: 3x4 pose matrix to quaternion plus flipped translation.
// Depends on pmq_pkg and pmq_col_norm.
//
//   channel  | valid       | stall       | payload
//   ---------+-------------+-------------+-------------------------------------
//   pose in  | pose_valid  | pose_stall  | rot_r0c0 .. rot_r2c2, trans_x/y/z
//   quat out | quat_valid  | quat_stall  | quat_x/y/z/w, pos_x/y/z
//
// One transfer is taken every cycle unless a valid output is stalled; the
// 32-step column root and the two bit-serial dividers are unrolled one step
// per stage.
// Reset clears only the stage valid bits. A stall on a valid output freezes the
// whole pipeline, bubbles included, and raises pose_stall in the same cycle.
`default_nettype none

module pose_matrix_to_quaternion #(
    parameter int FRAC_BITS = pmq_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pose_valid,
    output logic                 pose_stall,
    input  logic signed [31:0]   rot_r0c0,
    input  logic signed [31:0]   rot_r0c1,
    input  logic signed [31:0]   rot_r0c2,
    input  logic signed [31:0]   rot_r1c0,
    input  logic signed [31:0]   rot_r1c1,
    input  logic signed [31:0]   rot_r1c2,
    input  logic signed [31:0]   rot_r2c0,
    input  logic signed [31:0]   rot_r2c1,
    input  logic signed [31:0]   rot_r2c2,
    input  logic signed [31:0]   trans_x,
    input  logic signed [31:0]   trans_y,
    input  logic signed [31:0]   trans_z,
    output logic                 quat_valid,
    input  logic                 quat_stall,
    output logic signed [17:0]   quat_x,
    output logic signed [17:0]   quat_y,
    output logic signed [17:0]   quat_z,
    output logic signed [17:0]   quat_w,
    output logic signed [31:0]   pos_x,
    output logic signed [31:0]   pos_y,
    output logic signed [31:0]   pos_z
);

    localparam int F      = FRAC_BITS;
    localparam int MW     = F + 2;
    localparam int AW     = F + 4;
    localparam int DW     = F + 3;
    localparam int VW     = 2 * F + 3;
    localparam int RB     = F + 2;
    localparam int TW     = 2 * F + 5;
    localparam int UW     = 2 * F + 2;
    localparam int QD     = 2 * F + 1;
    localparam int DVW    = RB + 2 + QD;
    localparam int CN_LAT = pmq_pkg::cn_latency(F);
    localparam int QL     = CN_LAT + RB + QD + 4;
    localparam logic signed [AW-1:0] ONE_A = AW'(64'sd1 <<< F);

    typedef enum logic [1:0] {
        BR_W,
        BR_X,
        BR_Y,
        BR_Z
    } branch_t;

    logic          adv;
    logic [QL-1:0] vld_reg;

    logic signed [31:0] posx_reg [QL];
    logic signed [31:0] posy_reg [QL];
    logic signed [31:0] posz_reg [QL];

    logic signed [31:0]   col_in [3][3];
    logic signed [MW-1:0] col_nrm [3][3];

    branch_t              br1_next, br1_reg;
    logic signed [AW-1:0] a1_next, a1_reg;
    logic signed [DW-1:0] d1_next [3];
    logic signed [DW-1:0] d1_reg [3];

    logic [VW-1:0]        sqrem_reg [RB];
    logic [VW-1:0]        sqrem_next [RB];
    logic [RB-1:0]        sqroot_reg [RB];
    logic [RB-1:0]        sqroot_next [RB];
    branch_t              sqbr_reg [RB];
    branch_t              sqbr_next [RB];
    logic signed [DW-1:0] sqd_reg [RB][3];
    logic signed [DW-1:0] sqd_next [RB][3];

    logic [RB:0]          rr_next, rr_reg;
    logic [RB-1:0]        half_next, rhalf_reg;
    branch_t              rbr_reg;
    logic signed [DW-1:0] rd_reg [3];

    logic [UW-1:0]   un_reg [3];
    logic [UW-1:0]   un_next [3];
    logic [RB+1:0]   uden_reg;
    logic [2:0]      uneg_reg, uneg_next;
    branch_t         ubr_reg;
    logic [RB-1:0]   uhalf_reg;

    logic [2:0][UW-1:0] dvrem_reg [QD];
    logic [2:0][UW-1:0] dvrem_next [QD];
    logic [2:0][QD-1:0] dvq_reg [QD];
    logic [2:0][QD-1:0] dvq_next [QD];
    logic [RB+1:0]      dvden_reg [QD];
    logic [RB+1:0]      dvden_next [QD];
    logic [2:0]         dvneg_reg [QD];
    logic [2:0]         dvneg_next [QD];
    branch_t            dvbr_reg [QD];
    branch_t            dvbr_next [QD];
    logic [RB-1:0]      dvhalf_reg [QD];
    logic [RB-1:0]      dvhalf_next [QD];

    logic signed [17:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [17:0] qx_next, qy_next, qz_next, qw_next;

    // The output register frees up whenever it is empty or being taken.
    assign adv        = !quat_valid || !quat_stall;
    assign pose_stall = !adv;
    assign quat_valid = vld_reg[QL-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[QL-2:0], pose_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            posx_reg[0] <= (trans_x == pmq_pkg::POS_MIN) ? pmq_pkg::POS_MAX : -trans_x;
            posy_reg[0] <= trans_y;
            posz_reg[0] <= (trans_z == pmq_pkg::POS_MIN) ? pmq_pkg::POS_MAX : -trans_z;
            for (int i = 1; i < QL; i++)
            begin
                posx_reg[i] <= posx_reg[i-1];
                posy_reg[i] <= posy_reg[i-1];
                posz_reg[i] <= posz_reg[i-1];
            end
        end
    end

    assign col_in[0][0] = rot_r0c0;
    assign col_in[0][1] = rot_r1c0;
    assign col_in[0][2] = rot_r2c0;
    assign col_in[1][0] = rot_r0c1;
    assign col_in[1][1] = rot_r1c1;
    assign col_in[1][2] = rot_r2c1;
    assign col_in[2][0] = rot_r0c2;
    assign col_in[2][1] = rot_r1c2;
    assign col_in[2][2] = rot_r2c2;

    for (genvar c = 0; c < 3; c++)
    begin : g_col
        pmq_col_norm #(
            .FRAC_BITS (FRAC_BITS)
        ) u_col_norm (
            .clk (clk),
            .adv (adv),
            .ent (col_in[c]),
            .nrm (col_nrm[c])
        );
    end

    // Trace method: pick the branch, the root argument and the three numerators.
    always_comb
    begin
        logic signed [AW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22, t;
        e00 = AW'(col_nrm[0][0]);
        e10 = AW'(col_nrm[0][1]);
        e20 = AW'(col_nrm[0][2]);
        e01 = AW'(col_nrm[1][0]);
        e11 = AW'(col_nrm[1][1]);
        e21 = AW'(col_nrm[1][2]);
        e02 = AW'(col_nrm[2][0]);
        e12 = AW'(col_nrm[2][1]);
        e22 = AW'(col_nrm[2][2]);
        t   = e00 + e11 + e22;
        if (!t[AW-1])
        begin
            br1_next   = BR_W;
            a1_next    = t + ONE_A;
            d1_next[0] = DW'(e21 - e12);
            d1_next[1] = DW'(e02 - e20);
            d1_next[2] = DW'(e10 - e01);
        end
        else if (e00 > e11 && e00 > e22)
        begin
            br1_next   = BR_X;
            a1_next    = ONE_A + e00 - e11 - e22;
            d1_next[0] = DW'(e10 + e01);
            d1_next[1] = DW'(e02 + e20);
            d1_next[2] = DW'(e21 - e12);
        end
        else if (e11 > e22)
        begin
            br1_next   = BR_Y;
            a1_next    = ONE_A + e11 - e00 - e22;
            d1_next[0] = DW'(e10 + e01);
            d1_next[1] = DW'(e21 + e12);
            d1_next[2] = DW'(e02 - e20);
        end
        else
        begin
            br1_next   = BR_Z;
            a1_next    = ONE_A + e22 - e00 - e11;
            d1_next[0] = DW'(e02 + e20);
            d1_next[1] = DW'(e21 + e12);
            d1_next[2] = DW'(e10 - e01);
        end
    end

    // Integer root of the argument scaled up by the fraction width, one bit per stage.
    always_comb
    begin
        logic [VW-1:0] rin;
        logic [RB-1:0] qin;
        logic [TW-1:0] trial;
        for (int j = 0; j < RB; j++)
        begin
            if (j == 0)
            begin
                rin          = (a1_reg > 0) ? {a1_reg[F+2:0], {F{1'b0}}} : '0;
                qin          = '0;
                sqbr_next[j] = br1_reg;
                sqd_next[j]  = d1_reg;
            end
            else
            begin
                rin          = sqrem_reg[j-1];
                qin          = sqroot_reg[j-1];
                sqbr_next[j] = sqbr_reg[j-1];
                sqd_next[j]  = sqd_reg[j-1];
            end
            trial = ({{(TW-RB){1'b0}}, qin} << (RB - j))
                  + (TW'(1) << (2 * (RB - 1 - j)));
            if ({{(TW-VW){1'b0}}, rin} >= trial)
            begin
                sqrem_next[j]  = rin - trial[VW-1:0];
                sqroot_next[j] = qin | (RB'(1) << (RB - 1 - j));
            end
            else
            begin
                sqrem_next[j]  = rin;
                sqroot_next[j] = qin;
            end
        end
    end

    // Round the root to nearest; a zero root divides as one LSB.
    always_comb
    begin
        logic [RB-1:0] rt;
        logic [RB:0]   r;
        logic [RB:0]   rp;
        rt = sqroot_reg[RB-1];
        r  = (RB+1)'(rt) + (RB+1)'(sqrem_reg[RB-1] > {{(VW-RB){1'b0}}, rt});
        rp = r + (RB+1)'(1);
        half_next = rp[RB:1];
        rr_next   = (r == '0) ? (RB+1)'(1) : r;
    end

    always_comb
    begin
        logic [DW-1:0] dm;
        for (int k = 0; k < 3; k++)
        begin
            dm           = rd_reg[k][DW-1] ? DW'(-rd_reg[k]) : DW'(rd_reg[k]);
            un_next[k]   = UW'({dm, {F{1'b0}}}) + UW'(rr_reg);
            uneg_next[k] = rd_reg[k][DW-1];
        end
    end

    always_comb
    begin
        logic [2:0][UW-1:0] rin;
        logic [2:0][QD-1:0] qin;
        logic [RB+1:0]      din;
        logic [DVW-1:0]     dd;
        for (int j = 0; j < QD; j++)
        begin
            if (j == 0)
            begin
                rin            = {un_reg[2], un_reg[1], un_reg[0]};
                qin            = '0;
                din            = uden_reg;
                dvneg_next[j]  = uneg_reg;
                dvbr_next[j]   = ubr_reg;
                dvhalf_next[j] = uhalf_reg;
            end
            else
            begin
                rin            = dvrem_reg[j-1];
                qin            = dvq_reg[j-1];
                din            = dvden_reg[j-1];
                dvneg_next[j]  = dvneg_reg[j-1];
                dvbr_next[j]   = dvbr_reg[j-1];
                dvhalf_next[j] = dvhalf_reg[j-1];
            end
            dd            = {{(DVW-RB-2){1'b0}}, din} << (QD - 1 - j);
            dvden_next[j] = din;
            for (int k = 0; k < 3; k++)
            begin
                if ({{(DVW-UW){1'b0}}, rin[k]} >= dd)
                begin
                    dvrem_next[j][k] = rin[k] - dd[UW-1:0];
                    dvq_next[j][k]   = qin[k] | (QD'(1) << (QD - 1 - j));
                end
                else
                begin
                    dvrem_next[j][k] = rin[k];
                    dvq_next[j][k]   = qin[k];
                end
            end
        end
    end

    always_comb
    begin
        logic signed [63:0] qv [3];
        logic signed [63:0] hv, vx, vy, vz, vw;
        for (int k = 0; k < 3; k++)
        begin
            qv[k] = dvneg_reg[QD-1][k] ? -$signed(64'(dvq_reg[QD-1][k]))
                                       : $signed(64'(dvq_reg[QD-1][k]));
        end
        hv = $signed(64'(dvhalf_reg[QD-1]));
        case (dvbr_reg[QD-1])
            BR_W:
            begin
                vx = qv[0]; vy = qv[1]; vz = qv[2]; vw = hv;
            end
            BR_X:
            begin
                vx = hv;    vy = qv[0]; vz = qv[1]; vw = qv[2];
            end
            BR_Y:
            begin
                vx = qv[0]; vy = hv;    vz = qv[1]; vw = qv[2];
            end
            BR_Z:
            begin
                vx = qv[0]; vy = qv[1]; vz = hv;    vw = qv[2];
            end
            default:
            begin
                vx = '0;    vy = '0;    vz = '0;    vw = '0;
            end
        endcase
        qx_next = pmq_pkg::sat_quat(-vx);
        qy_next = pmq_pkg::sat_quat(vy);
        qz_next = pmq_pkg::sat_quat(-vz);
        qw_next = pmq_pkg::sat_quat(vw);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            br1_reg    <= br1_next;
            a1_reg     <= a1_next;
            d1_reg     <= d1_next;
            sqrem_reg  <= sqrem_next;
            sqroot_reg <= sqroot_next;
            sqbr_reg   <= sqbr_next;
            sqd_reg    <= sqd_next;
            rr_reg     <= rr_next;
            rhalf_reg  <= half_next;
            rbr_reg    <= sqbr_reg[RB-1];
            rd_reg     <= sqd_reg[RB-1];
            un_reg     <= un_next;
            uden_reg   <= {rr_reg, 1'b0};
            uneg_reg   <= uneg_next;
            ubr_reg    <= rbr_reg;
            uhalf_reg  <= rhalf_reg;
            dvrem_reg  <= dvrem_next;
            dvq_reg    <= dvq_next;
            dvden_reg  <= dvden_next;
            dvneg_reg  <= dvneg_next;
            dvbr_reg   <= dvbr_next;
            dvhalf_reg <= dvhalf_next;
            qx_reg     <= qx_next;
            qy_reg     <= qy_next;
            qz_reg     <= qz_next;
            qw_reg     <= qw_next;
        end
    end

    assign quat_x = qx_reg;
    assign quat_y = qy_reg;
    assign quat_z = qz_reg;
    assign quat_w = qw_reg;
    assign pos_x  = posx_reg[QL-1];
    assign pos_y  = posy_reg[QL-1];
    assign pos_z  = posz_reg[QL-1];

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && quat_stall |-> pose_stall)
        else $error("input taken while the output is held");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        pose_valid && !pose_stall |=> vld_reg[0])
        else $error("accepted pose did not enter the pipeline");

    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[CN_LAT+RB] |-> ({1'b0, sqroot_reg[RB-1]} <= ((RB+1)'(1) << (F + 1))))
        else $error("quaternion root out of range");

endmodule

`default_nettype wire
